// ----- rtl/cpts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpts_pkg
// Types and constants shared by the counter-priority task scheduler.
// ----------------------------------------------------------------------------
package cpts_pkg;

  // Request kinds
  typedef enum logic [2:0] {
    K_TICK     = 3'd0,
    K_YIELD    = 3'd1,
    K_EXIT     = 3'd2,
    K_HOLD_ON  = 3'd3,
    K_HOLD_OFF = 3'd4,
    K_INSTALL  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CUR,
    S_PASS,
    S_EVAL,
    S_DONE
  } state_e;

  // One task slot entry of the table
  typedef struct packed {
    logic signed [15:0] count;
    logic [7:0]         weight;
    logic [7:0]         hold;
  } entry_t;

  localparam int PASS_W = 5;
  localparam logic [PASS_W-1:0] RECOMPUTE_LIMIT = 5'd17;
  localparam logic signed [15:0] COUNT_MIN = -16'sd32768;
  localparam logic [7:0] HOLD_MAX = 8'd255;

endpackage : cpts_pkg
`default_nettype wire

// ----- rtl/cpts_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpts_table
// Task slot table: one write port, one registered read port. Entries that
// were never written read as their reset value.
// ----------------------------------------------------------------------------
module cpts_table
  import cpts_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
  output entry_t                        rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
  input  entry_t                        wr_data
);

  localparam int IW = $clog2(SLOTS);

  entry_t           mem [SLOTS];
  entry_t           mem_q;
  logic [SLOTS-1:0] written;
  logic             ok_q;
  logic             zero_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      ok_q    <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      ok_q   <= written[rd_addr];
      zero_q <= (rd_addr == IW'(0));
    end
  end

  // slot 0 starts with weight one, all other fields start at zero
  always_comb begin
    if (ok_q) begin
      rd_data = mem_q;
    end else begin
      rd_data.count  = '0;
      rd_data.weight = zero_q ? 8'd1 : 8'd0;
      rd_data.hold   = '0;
    end
  end

endmodule : cpts_table
`default_nettype wire

// ----- rtl/counter_priority_task_scheduler_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler_unit
// Counter-priority task scheduler with a sequenced scan over the slot table.
//
// Requests (kind, slot, prio, start_count) enter on req_valid/req_stall; one
// response (running_slot, switched, status) leaves on rsp_valid/rsp_stall for
// every request. One request is worked at a time; req_stall is high from
// acceptance until the response is loaded into the output register.
// Install, preempt disable/enable and unknown kinds, and a tick that does not
// reschedule, reach the response register without a scan of the table.
// A reschedule makes one scan pass over all slots, plus one per counter recompute (0 to 17).
// The slot table's one read port sets the pace: each scan or recompute pass
// reads one entry per cycle through one add/compare unit.
// Reset puts slot 0 present and running with weight one, all counters and
// hold counts at zero, and the current slot at 0; no clearing pass is needed.
// A stalled response stays in its register; a new request may be accepted
// meanwhile and finishes once the register is free.
// ----------------------------------------------------------------------------
module counter_priority_task_scheduler_unit
  import cpts_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic [2:0] kind,
  input  wire logic [5:0] slot,
  input  wire logic [7:0] prio,
  input  wire logic [8:0] start_count,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output logic [5:0]      running_slot,
  output logic            switched,
  output logic            status
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] ISS_END = CW'(SLOTS);
  localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

  state_e state, state_next;

  logic [2:0]        k_r;
  logic [IW-1:0]     now_slot;
  logic [SLOTS-1:0]  present;
  logic [SLOTS-1:0]  alive;
  logic [CW-1:0]     iss_cnt;
  logic              dat_vld;
  logic [IW-1:0]     dat_idx;
  logic              recomp;
  logic signed [15:0] best;
  logic [IW-1:0]     best_slot;
  logic [PASS_W-1:0] passes;
  logic              sw_r;
  logic              stuck_r;

  logic              accept;
  logic              slot_ok;
  logic              issuing;
  logic              pass_last;
  logic              take;
  logic              cur_sched;
  logic              rsp_load;
  logic              enter_pass;
  logic [IW-1:0]     rd_addr;
  entry_t            rd_data;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  entry_t            wr_data;
  logic signed [15:0] d_cnt;
  logic signed [15:0] pass_val;
  logic signed [15:0] tick_cnt;

  cpts_table #(
    .SLOTS(SLOTS)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign slot_ok   = ({2'b00, slot} < 8'(SLOTS - 1)) || ({2'b00, slot} == 8'(SLOTS - 1));
  assign issuing   = (iss_cnt < ISS_END);
  assign pass_last = dat_vld && (dat_idx == IDX_LAST);
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);
  assign enter_pass = (state_next == S_PASS) && (state != S_PASS);

  // shared add/compare unit
  assign d_cnt    = rd_data.count;
  assign tick_cnt = (d_cnt != COUNT_MIN) ? d_cnt - 16'sd1 : d_cnt;
  assign pass_val = recomp ? (d_cnt >>> 1) + $signed({8'd0, rd_data.weight}) : d_cnt;
  assign take     = dat_vld && present[dat_idx] && alive[dat_idx] && (pass_val > best);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind) inside
            K_TICK, K_YIELD, K_EXIT, K_HOLD_ON, K_HOLD_OFF: state_next = S_CUR;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_CUR: begin
        state_next = cur_sched ? S_PASS : S_DONE;
      end
      S_PASS: begin
        if (pass_last) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (best != 16'sd0 || passes == RECOMPUTE_LIMIT) begin
          state_next = S_DONE;
        end else begin
          state_next = S_PASS;
        end
      end
      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // table port control
  always_comb begin
    rd_addr   = now_slot;
    wr_en     = 1'b0;
    wr_addr   = now_slot;
    wr_data   = rd_data;
    cur_sched = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && kind == K_INSTALL && slot_ok) begin
          wr_en          = 1'b1;
          wr_addr        = IW'(slot);
          wr_data.count  = $signed({7'd0, start_count});
          wr_data.weight = prio;
          wr_data.hold   = '0;
        end
      end
      S_CUR: begin
        wr_en = 1'b1;
        case (k_r) inside
          K_TICK: begin
            if (tick_cnt > 16'sd0 || rd_data.hold != 8'd0) begin
              wr_data.count = tick_cnt;
            end else begin
              wr_data.count = '0;
              cur_sched     = 1'b1;
            end
          end
          K_YIELD, K_EXIT: begin
            wr_data.count = '0;
            cur_sched     = 1'b1;
          end
          K_HOLD_ON: begin
            if (rd_data.hold != HOLD_MAX) begin
              wr_data.hold = rd_data.hold + 8'd1;
            end
          end
          K_HOLD_OFF: begin
            if (rd_data.hold != 8'd0) begin
              wr_data.hold = rd_data.hold - 8'd1;
            end
          end
          default: wr_en = 1'b0;
        endcase
      end
      S_PASS: begin
        rd_addr       = iss_cnt[IW-1:0];
        wr_en         = dat_vld && recomp && present[dat_idx];
        wr_addr       = dat_idx;
        wr_data.count = pass_val;
      end
      S_EVAL, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      now_slot  <= '0;
      present   <= SLOTS'(1);
      alive     <= SLOTS'(1);
      rsp_valid <= 1'b0;
      iss_cnt   <= '0;
      dat_vld   <= 1'b0;
      recomp    <= 1'b0;
      passes    <= '0;
      sw_r      <= 1'b0;
      stuck_r   <= 1'b0;
    end else begin
      state <= state_next;

      if (accept) begin
        k_r     <= kind;
        sw_r    <= 1'b0;
        stuck_r <= 1'b0;
        passes  <= '0;
        recomp  <= 1'b0;
        if (kind == K_INSTALL && slot_ok) begin
          present[IW'(slot)] <= 1'b1;
          alive[IW'(slot)]   <= 1'b1;
        end
      end

      if (state == S_CUR && k_r == K_EXIT) begin
        alive[now_slot] <= 1'b0;
      end

      if (enter_pass) begin
        iss_cnt   <= '0;
        dat_vld   <= 1'b0;
        best      <= -16'sd1;
        best_slot <= '0;
      end else if (state == S_PASS) begin
        if (issuing) begin
          iss_cnt <= iss_cnt + CW'(1);
        end
        dat_vld <= issuing;
        dat_idx <= rd_addr;
        if (take) begin
          best      <= pass_val;
          best_slot <= dat_idx;
        end
      end

      if (state == S_EVAL) begin
        if (best != 16'sd0) begin
          now_slot <= best_slot;
          sw_r     <= (best_slot != now_slot);
        end else if (passes == RECOMPUTE_LIMIT) begin
          stuck_r <= 1'b1;
        end else begin
          passes <= passes + PASS_W'(1);
          recomp <= 1'b1;
        end
      end

      // output register
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      running_slot <= 6'(now_slot);
      switched     <= sw_r;
      status       <= stuck_r;
    end
  end

`ifndef SYNTHESIS
  a_cur_present: assert property (@(posedge clk) disable iff (rst)
    present[now_slot])
    else $error("current slot is not present");

  a_stuck_no_switch: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(status && switched))
    else $error("stuck response reports a task switch");

  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    passes <= RECOMPUTE_LIMIT)
    else $error("recompute count over limit");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("request accepted without leaving idle");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_DONE))
    else $error("response loaded outside done state");
`endif

endmodule : counter_priority_task_scheduler_unit
`default_nettype wire

// ----- sim/tb_counter_priority_task_scheduler_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_counter_priority_task_scheduler_unit
// Drives scheduler requests (tick, yield, exit, preempt hold, install) through
// the request channel and keeps a cycle-free copy of the slot table that
// predicts every response. The directed opening covers field extremes, the
// stuck case and the no-runnable fallback to slot 0. Random traffic follows.
// A closing run pins the hold count at its top and ticks the held task's
// counter down. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_counter_priority_task_scheduler_unit;
  import cpts_pkg::*;

  localparam int SLOTS = 64;
  localparam int RANDOM_ITEMS = 1300;
  localparam int TAIL_ITEMS = 150;
  localparam int HOLD_RUN = 260;
  localparam int HELD_TICKS = 40;
  localparam int LONG_HOLD_OFF = 200;
  localparam int LONG_HOLD_AT = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 50;
  // kinds with no effect on the block
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] slot;
    logic [7:0] prio;
    logic [8:0] start_count;
  } sched_req_t;

  typedef struct packed {
    logic [5:0] running_slot;
    logic       switched;
    logic       status;
  } sched_rsp_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic [5:0] running_slot;
  logic       switched;
  logic       status;
  sched_req_t on_wire = '0;

  // predicted slot table
  bit                 on_table [SLOTS];
  bit                 live     [SLOTS];
  logic signed [15:0] ctr      [SLOTS];
  logic [7:0]         wt       [SLOTS];
  logic [7:0]         hold     [SLOTS];
  logic [5:0]         cur_slot;

  sched_req_t pending_q [$];
  sched_rsp_t schedule_q [$];
  sched_rsp_t want;
  int         sent_count = 0;
  int         rsp_seen = 0;
  int         fail_count = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  bit         long_done = 1'b0;
  int         idle_cycles = 0;

  counter_priority_task_scheduler_unit #(.SLOTS(SLOTS)) DUT (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .kind        (on_wire.kind),
    .slot        (on_wire.slot),
    .prio        (on_wire.prio),
    .start_count (on_wire.start_count),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .running_slot(running_slot),
    .switched    (switched),
    .status      (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      on_table[i] = 1'b0;
      live[i]     = 1'b0;
      ctr[i]      = '0;
      wt[i]       = '0;
      hold[i]     = '0;
    end
    on_table[0] = 1'b1;
    live[0]     = 1'b1;
    wt[0]       = 8'd1;
    cur_slot    = '0;
  endtask

  // largest non-negative counter among running slots, lowest slot on ties
  function automatic int pick_longest(output int winner);
    int top;
    top    = -1;
    winner = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (on_table[i] && live[i] && int'(ctr[i]) > top) begin
        top    = int'(ctr[i]);
        winner = i;
      end
    end
    return top;
  endfunction

  // returns 1 when no pick could be made
  function automatic bit reschedule();
    int top;
    int winner;
    int c;
    for (int pass = 0; pass <= int'(RECOMPUTE_LIMIT); pass++) begin
      top = pick_longest(winner);
      if (top != 0) begin
        cur_slot = winner[5:0];
        return 1'b0;
      end
      if (pass < int'(RECOMPUTE_LIMIT)) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (on_table[i]) begin
            c = int'(ctr[i]);
            ctr[i] = 16'((c >>> 1) + int'(wt[i]));
          end
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic sched_rsp_t apply_request(sched_req_t rq);
    logic [5:0] was;
    bit         stuck;
    sched_rsp_t r;
    was   = cur_slot;
    stuck = 1'b0;
    case (rq.kind)
      K_TICK: begin
        if (ctr[cur_slot] > COUNT_MIN) ctr[cur_slot] = ctr[cur_slot] - 16'sd1;
        if (!(ctr[cur_slot] > 16'sd0 || hold[cur_slot] != 8'd0)) begin
          ctr[cur_slot] = '0;
          stuck = reschedule();
        end
      end
      K_YIELD: begin
        ctr[cur_slot] = '0;
        stuck = reschedule();
      end
      K_EXIT: begin
        live[cur_slot] = 1'b0;
        ctr[cur_slot]  = '0;
        stuck = reschedule();
      end
      K_HOLD_ON: begin
        if (hold[cur_slot] < HOLD_MAX) hold[cur_slot] = hold[cur_slot] + 8'd1;
      end
      K_HOLD_OFF: begin
        if (hold[cur_slot] > 8'd0) hold[cur_slot] = hold[cur_slot] - 8'd1;
      end
      K_INSTALL: begin
        on_table[rq.slot] = 1'b1;
        live[rq.slot]     = 1'b1;
        ctr[rq.slot]      = {7'd0, rq.start_count};
        wt[rq.slot]       = rq.prio;
        hold[rq.slot]     = '0;
      end
      default: ;
    endcase
    r.running_slot = cur_slot;
    r.switched     = (cur_slot != was);
    r.status       = stuck;
    return r;
  endfunction

  task automatic queue_req(input logic [2:0] k, input logic [5:0] s,
                           input logic [7:0] p, input logic [8:0] c);
    sched_req_t rq;
    rq.kind        = k;
    rq.slot        = s;
    rq.prio        = p;
    rq.start_count = c;
    pending_q.push_back(rq);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left  <= 0;
    end else begin
      if (req_valid && !req_stall) schedule_q.push_back(apply_request(on_wire));
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left  <= gap_left - 1;
          req_valid <= 1'b0;
        end else if (!((sent_count / 150) % 3 == 2 || pending_q.size() < TAIL_ITEMS) &&
                     $urandom_range(0, 4) == 0) begin
          gap_left  <= $urandom_range(0, 3);
          req_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          on_wire    <= pending_q.pop_front();
          req_valid  <= 1'b1;
          sent_count <= sent_count + 1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response stall: short random bursts, one long hold-off to back up the block
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
    end else if (!long_done && rsp_seen >= LONG_HOLD_AT) begin
      long_done  <= 1'b1;
      stall_left <= LONG_HOLD_OFF;
      rsp_stall  <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_stall  <= 1'b1;
    end else if (!((rsp_seen / 120) % 3 == 1 || pending_q.size() < TAIL_ITEMS) &&
                 $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      rsp_stall  <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // response checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_seen <= rsp_seen + 1;
      if (schedule_q.size() == 0) begin
        $error("response with no request outstanding: running_slot %0d", running_slot);
        fail_count++;
      end else begin
        want = schedule_q.pop_front();
        if (running_slot !== want.running_slot) begin
          $error("running_slot: expected %0d, got %0d", want.running_slot, running_slot);
          fail_count++;
        end
        if (switched !== want.switched) begin
          $error("switched: expected %0d, got %0d", want.switched, switched);
          fail_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL counter_priority_task_scheduler_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int         useful;
    int         r;
    sched_req_t rq;

    clear_table();

    // directed opening
    queue_req(K_TICK, 6'd0, 8'd0, 9'd0);          // recompute lifts slot 0
    queue_req(K_INSTALL, 6'd63, 8'd255, 9'd511);
    queue_req(K_INSTALL, 6'd1, 8'd0, 9'd0);
    queue_req(K_TICK, 6'd0, 8'd0, 9'd0);          // switch to the top counter
    queue_req(K_HOLD_ON, 6'd0, 8'd0, 9'd0);
    queue_req(K_TICK, 6'd0, 8'd0, 9'd0);
    queue_req(K_HOLD_OFF, 6'd0, 8'd0, 9'd0);
    queue_req(K_HOLD_OFF, 6'd0, 8'd0, 9'd0);      // floor of the hold count
    queue_req(KIND_SPARE_LO, 6'd63, 8'd255, 9'd511);
    queue_req(KIND_SPARE_HI, 6'd21, 8'd170, 9'd341);
    queue_req(K_INSTALL, 6'd63, 8'd200, 9'd1);    // overwrite the running slot
    queue_req(K_TICK, 6'd0, 8'd0, 9'd0);
    queue_req(K_YIELD, 6'd0, 8'd0, 9'd0);
    queue_req(K_EXIT, 6'd0, 8'd0, 9'd0);
    queue_req(K_EXIT, 6'd0, 8'd0, 9'd0);          // only a zero-weight task left: stuck
    queue_req(K_YIELD, 6'd0, 8'd0, 9'd0);
    queue_req(K_INSTALL, 6'd1, 8'd0, 9'd5);
    queue_req(K_YIELD, 6'd0, 8'd0, 9'd0);
    queue_req(K_EXIT, 6'd0, 8'd0, 9'd0);          // nothing running: fall back to slot 0
    queue_req(K_TICK, 6'd0, 8'd0, 9'd0);
    queue_req(K_INSTALL, 6'd42, 8'd85, 9'd170);
    queue_req(K_INSTALL, 6'd21, 8'd170, 9'd341);
    queue_req(K_YIELD, 6'd0, 8'd0, 9'd0);
    queue_req(K_HOLD_ON, 6'd0, 8'd0, 9'd0);
    queue_req(K_TICK, 6'd0, 8'd0, 9'd0);

    // random traffic, mostly on a few slots so tasks come and go
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 25)      rq.kind = K_INSTALL;
      else if (r < 58) rq.kind = K_TICK;
      else if (r < 70) rq.kind = K_YIELD;
      else if (r < 78) rq.kind = K_EXIT;
      else if (r < 87) rq.kind = K_HOLD_ON;
      else if (r < 96) rq.kind = K_HOLD_OFF;
      else             rq.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      rq.slot = ($urandom_range(0, 9) < 3) ? 6'($urandom_range(0, 63)) :
                                             6'($urandom_range(0, 7));
      r = $urandom_range(0, 15);
      rq.prio = (r < 2) ? 8'd0 : (r == 2) ? 8'd255 : 8'($urandom_range(0, 255));
      r = $urandom_range(0, 15);
      if (r < 2)       rq.start_count = 9'd0;
      else if (r == 2) rq.start_count = 9'd511;
      else if (r < 11) rq.start_count = 9'($urandom_range(0, 15));
      else             rq.start_count = 9'($urandom_range(0, 511));
      pending_q.push_back(rq);
      if (rq.kind != KIND_SPARE_LO && rq.kind != KIND_SPARE_HI) useful++;
    end

    // pin the hold count at its top, then tick the held counter down
    repeat (HOLD_RUN) queue_req(K_HOLD_ON, 6'd0, 8'd0, 9'd0);
    repeat (HELD_TICKS) queue_req(K_TICK, 6'd0, 8'd0, 9'd0);
    repeat (HOLD_RUN) queue_req(K_HOLD_OFF, 6'd0, 8'd0, 9'd0);
    queue_req(K_TICK, 6'd0, 8'd0, 9'd0);
    queue_req(K_YIELD, 6'd0, 8'd0, 9'd0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || req_valid || schedule_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS counter_priority_task_scheduler_unit");
    end else begin
      $display("FAIL counter_priority_task_scheduler_unit");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cpts_pkg.sv
rtl/cpts_table.sv
rtl/counter_priority_task_scheduler_unit.sv
sim/tb_counter_priority_task_scheduler_unit.sv
